### hw/rtl/cmc_pkg.sv
// Shared types and constants for the contour mean curvature block.
// Holds controller states, datapath op codes and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package cmc_pkg;

    // default cluster size limit
    localparam int MAX_POINTS_DEF = 1024;

    // 1000^2 * 4: curvature scale before the 2^32 fraction shift
    localparam logic [37:0] SCALE_K = 38'd4000000;

    // iteration counts of the shared divider and square root loops
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SMUL,
        ST_CHK,
        ST_LD_CR,
        ST_MUL_CR,
        ST_LD_K,
        ST_MUL_K,
        ST_LD_D1,
        ST_MUL_D1,
        ST_LD_D2,
        ST_MUL_D2,
        ST_LD_DIV,
        ST_DIV,
        ST_LD_SQ,
        ST_SQRT,
        ST_ACC,
        ST_UPD,
        ST_FIN,
        ST_LD_MEAN,
        ST_MEAN,
        ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_DIFF,
        DP_SMUL_STEP,
        DP_LD_CR,
        DP_LD_K,
        DP_LD_D1,
        DP_LD_D2,
        DP_MUL_STEP,
        DP_LD_DIV_TERM,
        DP_LD_DIV_MEAN,
        DP_DIV_STEP,
        DP_LD_SQRT,
        DP_SQRT_STEP,
        DP_ACC,
        DP_UPDATE,
        DP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic cnt_zero;
        logic smul_last;
        logic degenerate;
        logic last;
        logic cnt_ge2;
        logic cnt_ge3;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/cmc_datapath.sv
// Datapath of the contour mean curvature block: point history, small multiplier,
// serial shift-add multiplier, restoring divider, square root and output register.
// Depends on cmc_pkg.
`timescale 1ns / 1ps

module cmc_datapath import cmc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic signed [17:0] i_x_mm,
    input  logic signed [17:0] i_y_mm,
    input  logic               i_last,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [31:0]        o_mean_curvature,
    output logic               o_valid_res,
    output logic [10:0]        o_points_seen
);

    // captured beat
    logic signed [17:0] r_x, r_y;
    logic               r_last;
    // history and running state
    logic signed [17:0] r_px0, r_py0, r_px1, r_py1;
    logic [CNT_W-1:0]   r_count;
    logic [47:0]        r_sum;
    // triangle edges
    logic signed [18:0] r_ux, r_uy, r_vx, r_vy, r_wx, r_wy;
    logic [6:0]         r_cnt;
    logic signed [38:0] r_cr;
    logic [37:0]        r_d01, r_d02, r_d12;
    // serial multiplier
    logic [113:0]       r_mc, r_prod;
    logic [37:0]        r_mp;
    logic [97:0]        r_num;
    // divider
    logic [113:0]       r_den, r_rem;
    logic [63:0]        r_qsrc, r_q;
    // square root
    logic [63:0]        r_sx;
    logic [31:0]        r_root;
    logic [33:0]        r_srem;
    // output register
    logic               r_ovalid;
    logic [31:0]        r_omean;
    logic               r_ovres;
    logic [10:0]        r_opts;

    logic signed [18:0] s_a, s_b;
    logic signed [37:0] w_sp;
    logic signed [38:0] w_ncr;
    logic [37:0]        w_acr;
    logic [114:0]       w_rs, w_dv, w_diff;
    logic               w_ge;
    logic [35:0]        w_sr, w_trial;
    logic               w_sge;
    logic [48:0]        w_sum;
    logic               w_cnt_ge3;

    // small multiplier operand select
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin s_a = r_ux; s_b = r_vy; end
            3'd1:    begin s_a = r_uy; s_b = r_vx; end
            3'd2:    begin s_a = r_ux; s_b = r_ux; end
            3'd3:    begin s_a = r_uy; s_b = r_uy; end
            3'd4:    begin s_a = r_vx; s_b = r_vx; end
            3'd5:    begin s_a = r_vy; s_b = r_vy; end
            3'd6:    begin s_a = r_wx; s_b = r_wx; end
            3'd7:    begin s_a = r_wy; s_b = r_wy; end
            default: begin s_a = r_ux; s_b = r_vy; end
        endcase
    end

    assign w_sp  = s_a * s_b;
    assign w_ncr = -r_cr;
    assign w_acr = r_cr[38] ? w_ncr[37:0] : r_cr[37:0];

    // divider step
    assign w_rs   = {r_rem, r_qsrc[63]};
    assign w_dv   = {1'b0, r_den};
    assign w_ge   = (w_rs >= w_dv);
    assign w_diff = w_rs - w_dv;

    // square root step
    assign w_sr    = {r_srem, r_sx[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = (w_sr >= w_trial);

    assign w_sum     = {1'b0, r_sum} + 49'(r_root);
    assign w_cnt_ge3 = (r_count >= CNT_W'(3));

    // status to the controller
    always_comb begin
        o_sts.mul_done   = (r_mp == '0);
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.smul_last  = (r_cnt[2:0] == 3'd7);
        o_sts.degenerate = (r_cr == '0) || (r_d01 == '0) || (r_d02 == '0) || (r_d12 == '0);
        o_sts.last       = r_last;
        o_sts.cnt_ge2    = (r_count >= CNT_W'(2));
        o_sts.cnt_ge3    = w_cnt_ge3;
        o_sts.out_free   = !r_ovalid || i_ready;
    end

    // running state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px0    <= '0;
            r_py0    <= '0;
            r_px1    <= '0;
            r_py1    <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // a new result may replace one taken in the same cycle
            if (i_cmd.op == DP_OUT_LOAD) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                DP_ACC: begin
                    r_sum <= w_sum[48] ? '1 : w_sum[47:0];
                end
                DP_UPDATE: begin
                    r_px1 <= r_px0;
                    r_py1 <= r_py0;
                    r_px0 <= r_x;
                    r_py0 <= r_y;
                    if (r_count != CNT_W'(MAX_POINTS)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                DP_OUT_LOAD: begin
                    r_px0    <= '0;
                    r_py0    <= '0;
                    r_px1    <= '0;
                    r_py1    <= '0;
                    r_count  <= '0;
                    r_sum    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_x    <= i_x_mm;
                r_y    <= i_y_mm;
                r_last <= i_last;
            end
            DP_DIFF: begin
                r_ux  <= 19'(r_px0) - 19'(r_px1);
                r_uy  <= 19'(r_py0) - 19'(r_py1);
                r_vx  <= 19'(r_x) - 19'(r_px1);
                r_vy  <= 19'(r_y) - 19'(r_py1);
                r_wx  <= 19'(r_x) - 19'(r_px0);
                r_wy  <= 19'(r_y) - 19'(r_py0);
                r_cnt <= '0;
            end
            DP_SMUL_STEP: begin
                case (r_cnt[2:0])
                    3'd0:    r_cr  <= 39'(w_sp);
                    3'd1:    r_cr  <= r_cr - 39'(w_sp);
                    3'd2:    r_d01 <= unsigned'(w_sp);
                    3'd3:    r_d01 <= r_d01 + unsigned'(w_sp);
                    3'd4:    r_d02 <= unsigned'(w_sp);
                    3'd5:    r_d02 <= r_d02 + unsigned'(w_sp);
                    3'd6:    r_d12 <= unsigned'(w_sp);
                    3'd7:    r_d12 <= r_d12 + unsigned'(w_sp);
                    default: r_cr  <= r_cr;
                endcase
                r_cnt <= r_cnt + 7'd1;
            end
            DP_LD_CR: begin
                r_mc   <= 114'(w_acr);
                r_mp   <= w_acr;
                r_prod <= '0;
            end
            DP_LD_K: begin
                r_mc   <= r_prod;
                r_mp   <= SCALE_K;
                r_prod <= '0;
            end
            DP_LD_D1: begin
                r_num  <= r_prod[97:0];
                r_mc   <= 114'(r_d01);
                r_mp   <= r_d12;
                r_prod <= '0;
            end
            DP_LD_D2: begin
                r_mc   <= r_prod;
                r_mp   <= r_d02;
                r_prod <= '0;
            end
            DP_MUL_STEP: begin
                if (r_mp[0]) begin
                    r_prod <= r_prod + r_mc;
                end
                r_mc <= {r_mc[112:0], 1'b0};
                r_mp <= {1'b0, r_mp[37:1]};
            end
            // numerator is num98 * 2^32; its top 66 bits sit below the divisor
            DP_LD_DIV_TERM: begin
                r_den  <= r_prod;
                r_rem  <= 114'(r_num[97:32]);
                r_qsrc <= {r_num[31:0], 32'd0};
                r_q    <= '0;
                r_cnt  <= DIV_STEPS;
            end
            DP_LD_DIV_MEAN: begin
                r_den  <= 114'(r_count);
                r_rem  <= '0;
                r_qsrc <= 64'(r_sum);
                r_q    <= '0;
                r_cnt  <= DIV_STEPS;
            end
            DP_DIV_STEP: begin
                r_rem  <= w_ge ? w_diff[113:0] : w_rs[113:0];
                r_q    <= {r_q[62:0], w_ge};
                r_qsrc <= {r_qsrc[62:0], 1'b0};
                r_cnt  <= r_cnt - 7'd1;
            end
            DP_LD_SQRT: begin
                r_sx   <= r_q;
                r_root <= '0;
                r_srem <= '0;
                r_cnt  <= SQRT_STEPS;
            end
            DP_SQRT_STEP: begin
                r_srem <= w_sge ? 34'(w_sr - w_trial) : w_sr[33:0];
                r_root <= {r_root[30:0], w_sge};
                r_sx   <= {r_sx[61:0], 2'b00};
                r_cnt  <= r_cnt - 7'd1;
            end
            DP_OUT_LOAD: begin
                r_omean <= !w_cnt_ge3 ? 32'd0 : ((|r_q[63:32]) ? '1 : r_q[31:0]);
                r_ovres <= w_cnt_ge3;
                r_opts  <= 11'(r_count);
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_mean_curvature = r_omean;
    assign o_valid_res      = r_ovres;
    assign o_points_seen    = r_opts;

endmodule

### hw/rtl/cmc_ctrl.sv
// Controller of the contour mean curvature block: sequences the datapath ops.
// Depends on cmc_pkg.
`timescale 1ns / 1ps

module cmc_ctrl import cmc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_valid) n_state = i_sts.cnt_ge2 ? ST_DIFF : ST_UPD;
            ST_DIFF:    n_state = ST_SMUL;
            ST_SMUL:    if (i_sts.smul_last) n_state = ST_CHK;
            ST_CHK:     n_state = i_sts.degenerate ? ST_UPD : ST_LD_CR;
            ST_LD_CR:   n_state = ST_MUL_CR;
            ST_MUL_CR:  if (i_sts.mul_done) n_state = ST_LD_K;
            ST_LD_K:    n_state = ST_MUL_K;
            ST_MUL_K:   if (i_sts.mul_done) n_state = ST_LD_D1;
            ST_LD_D1:   n_state = ST_MUL_D1;
            ST_MUL_D1:  if (i_sts.mul_done) n_state = ST_LD_D2;
            ST_LD_D2:   n_state = ST_MUL_D2;
            ST_MUL_D2:  if (i_sts.mul_done) n_state = ST_LD_DIV;
            ST_LD_DIV:  n_state = ST_DIV;
            ST_DIV:     if (i_sts.cnt_zero) n_state = ST_LD_SQ;
            ST_LD_SQ:   n_state = ST_SQRT;
            ST_SQRT:    if (i_sts.cnt_zero) n_state = ST_ACC;
            ST_ACC:     n_state = ST_UPD;
            ST_UPD:     n_state = ST_FIN;
            ST_FIN: begin
                if (!i_sts.last)        n_state = ST_IDLE;
                else if (i_sts.cnt_ge3) n_state = ST_LD_MEAN;
                else                    n_state = ST_OUT;
            end
            ST_LD_MEAN: n_state = ST_MEAN;
            ST_MEAN:    if (i_sts.cnt_zero) n_state = ST_OUT;
            ST_OUT:     if (i_sts.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // op issue
    always_comb begin
        o_cmd.op = DP_NOP;
        o_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = DP_CAPTURE;
            end
            ST_DIFF:    o_cmd.op = DP_DIFF;
            ST_SMUL:    o_cmd.op = DP_SMUL_STEP;
            ST_LD_CR:   o_cmd.op = DP_LD_CR;
            ST_LD_K:    o_cmd.op = DP_LD_K;
            ST_LD_D1:   o_cmd.op = DP_LD_D1;
            ST_LD_D2:   o_cmd.op = DP_LD_D2;
            ST_MUL_CR, ST_MUL_K, ST_MUL_D1, ST_MUL_D2: begin
                if (!i_sts.mul_done) o_cmd.op = DP_MUL_STEP;
            end
            ST_LD_DIV:  o_cmd.op = DP_LD_DIV_TERM;
            ST_DIV, ST_MEAN: begin
                if (!i_sts.cnt_zero) o_cmd.op = DP_DIV_STEP;
            end
            ST_LD_SQ:   o_cmd.op = DP_LD_SQRT;
            ST_SQRT: begin
                if (!i_sts.cnt_zero) o_cmd.op = DP_SQRT_STEP;
            end
            ST_ACC:     o_cmd.op = DP_ACC;
            ST_UPD:     o_cmd.op = DP_UPDATE;
            ST_LD_MEAN: o_cmd.op = DP_LD_DIV_MEAN;
            ST_OUT: begin
                if (i_sts.out_free) o_cmd.op = DP_OUT_LOAD;
            end
            default:    o_cmd.op = DP_NOP;
        endcase
    end

endmodule

### hw/rtl/contour_mean_curvature.sv
// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_ready  i_x_mm, i_y_mm, i_last
// out      output     o_valid / i_ready  o_mean_curvature, o_valid_res, o_points_seen
//
// One point at a time. The first two points of a cluster and an interior point with a
// degenerate triangle skip the curvature term; any other interior point's time is set
// by the serial shift-add multiplier (one multiplier bit per step over four products
// of up to 38 bits), the 64-step divider and the 32-step root.
// A last point adds the mean division on the same divider (skipped when the cluster
// has fewer than three points), plus any wait for the output register.
// Reset (synchronous, active low) clears the history, count, sum and control.
// A waiting result does not block new points until another last point needs the
// output register.
`timescale 1ns / 1ps

module contour_mean_curvature import cmc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [17:0] i_x_mm,
    input  logic signed [17:0] i_y_mm,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_mean_curvature,
    output logic               o_valid_res,
    output logic [10:0]        o_points_seen
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    cmc_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_x_mm           (i_x_mm),
        .i_y_mm           (i_y_mm),
        .i_last           (i_last),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_mean_curvature (o_mean_curvature),
        .o_valid_res      (o_valid_res),
        .o_points_seen    (o_points_seen)
    );

endmodule

### test/cmc_checker.sv
// Checker for contour_mean_curvature: watches both channels, predicts each
// cluster's mean curvature and compares the output beats field by field.
// Depends on the RTL ports only (no package functions are used).
`timescale 1ns / 1ps

module cmc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [17:0] i_x_mm,
    input  logic signed [17:0] i_y_mm,
    input  logic               i_last,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [31:0]        o_mean_curvature,
    input  logic               o_valid_res,
    input  logic [10:0]        o_points_seen,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int          CLUSTER_CAP = 1024;
    localparam logic [47:0] SUM_CAP     = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [31:0] mean;
        logic        ok;
        logic [10:0] count;
    } t_cluster_res;

    t_cluster_res  mean_q[$];
    longint        hist_x[2];
    longint        hist_y[2];
    int            pts;
    logic [47:0]   curv_sum;

    // floored square root of a 64-bit value, bit by bit
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Menger curvature term, floor(65536 * 1000 * k) with k in 1/mm
    function automatic logic [63:0] curv_term(longint ax, longint ay, longint bx,
                                              longint by, longint cx, longint cy);
        longint       ux, uy, vx, vy, cr;
        logic [191:0] acr, k, s01, s02, s12, num, den, q;
        ux = bx - ax;
        uy = by - ay;
        vx = cx - ax;
        vy = cy - ay;
        cr = ux * vy - uy * vx;
        acr = (cr < 0) ? -cr : cr;
        s01 = ux * ux + uy * uy;
        s02 = vx * vx + vy * vy;
        s12 = (cx - bx) * (cx - bx) + (cy - by) * (cy - by);
        if (s01 == 0 || s02 == 0 || s12 == 0 || acr == 0) return 64'd0;
        k = 192'd4000000 << 32;
        num = acr * acr * k;
        den = s01 * s12 * s02;
        q = num / den;
        return root_floor(q[63:0]);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = mean_q.size();

    always @(posedge i_clk) begin
        logic [48:0]  acc;
        logic [47:0]  m;
        t_cluster_res r;
        t_cluster_res e;
        if (!i_rst_n) begin
            hist_x = '{0, 0};
            hist_y = '{0, 0};
            pts = 0;
            curv_sum = 0;
            mean_q.delete();
        end else begin
            // input beat: accumulate, close cluster on last
            if (i_valid && o_ready) begin
                if (pts >= 2) begin
                    acc = curv_sum + curv_term(hist_x[1], hist_y[1], hist_x[0], hist_y[0],
                                               i_x_mm, i_y_mm);
                    curv_sum = (acc > SUM_CAP) ? SUM_CAP : acc[47:0];
                end
                hist_x[1] = hist_x[0];
                hist_y[1] = hist_y[0];
                hist_x[0] = i_x_mm;
                hist_y[0] = i_y_mm;
                if (pts < CLUSTER_CAP) pts++;
                if (i_last) begin
                    if (pts >= 3) begin
                        m = curv_sum / pts;
                        r.mean = (m > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
                        r.ok = 1'b1;
                    end else begin
                        r.mean = 0;
                        r.ok = 1'b0;
                    end
                    r.count = pts[10:0];
                    mean_q.insert(mean_q.size(), r);
                    hist_x = '{0, 0};
                    hist_y = '{0, 0};
                    pts = 0;
                    curv_sum = 0;
                end
            end
            // output beat: compare against oldest prediction
            if (o_valid && i_ready) begin
                if (mean_q.size() == 0) begin
                    report("unexpected beat", o_mean_curvature, 0);
                end else begin
                    e = mean_q.pop_front();
                    if (o_mean_curvature !== e.mean)
                        report("mean_curvature", o_mean_curvature, e.mean);
                    if (o_valid_res !== e.ok) report("valid_res", o_valid_res, e.ok);
                    if (o_points_seen !== e.count)
                        report("points_seen", o_points_seen, e.count);
                end
            end
        end
    end

endmodule

### test/tb.sv
// Top of the contour_mean_curvature testbench: clock, reset, point stimulus,
// output back-pressure, watchdog and verdict. Uses cmc_checker for prediction.
`timescale 1ns / 1ps

module tb;

    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int LONG_PTS    = 1030;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic signed [17:0] i_x_mm = 0;
    logic signed [17:0] i_y_mm = 0;
    logic               i_last = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic [31:0]        o_mean_curvature;
    logic               o_valid_res;
    logic [10:0]        o_points_seen;

    int   errors, pending;
    int   tx_idle = 37;
    int   rx_idle = 81;
    logic hold_go = 0;
    logic hold_done = 0;
    int   hold_cnt = 0;
    int   quiet = 0;

    contour_mean_curvature dut (.*);

    cmc_checker chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_x_mm, .i_y_mm, .i_last,
        .o_valid, .i_ready, .o_mean_curvature, .o_valid_res, .o_points_seen,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_cnt <= HOLD_CYCLES;
            i_ready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one point beat; optional gap first, valid stays high between beats
    task automatic send_point(longint x, longint y, logic lst);
        logic hit;
        if ($urandom_range(99) < tx_idle) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_x_mm <= 18'(x);
        i_y_mm <= 18'(y);
        i_last <= lst;
        do begin
            @(negedge i_clk);
            hit = o_ready;
            @(posedge i_clk);
        end while (!hit);
    endtask

    // random cluster: mostly points around a center with a chosen spread
    task automatic send_cluster(int n);
        longint cx, cy, sp;
        int     mode;
        mode = $urandom_range(9);
        sp = (mode < 3) ? $urandom_range(1, 4) : (mode < 6) ? $urandom_range(5, 300) :
             (mode < 8) ? $urandom_range(301, 30000) : 131071;
        cx = $signed($urandom_range(262143)) - 131072;
        cy = $signed($urandom_range(262143)) - 131072;
        for (int i = 0; i < n; i++) begin
            longint x, y;
            if (sp == 131071 || $urandom_range(19) == 0) begin
                x = longint'($urandom_range(262143)) - 131072;
                y = longint'($urandom_range(262143)) - 131072;
            end else begin
                x = cx + longint'($urandom_range(2 * sp)) - sp;
                y = cy + longint'($urandom_range(2 * sp)) - sp;
                if (x > 131071) x = 131071;
                if (x < -131072) x = -131072;
                if (y > 131071) y = 131071;
                if (y < -131072) y = -131072;
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    initial begin
        int sent, n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: single and two-point clusters
        send_point(5, 5, 1);
        send_point(-131072, 131071, 0);
        send_point(131071, -131072, 1);
        // extreme corners
        send_point(-131072, -131072, 0);
        send_point(131071, -131072, 0);
        send_point(131071, 131071, 1);
        // tiny right triangle, highest curvature
        send_point(0, 0, 0);
        send_point(1, 0, 0);
        send_point(0, 1, 1);
        // collinear points
        send_point(-10, -10, 0);
        send_point(0, 0, 0);
        send_point(10, 10, 0);
        send_point(20, 20, 1);
        // coincident points
        send_point(7, -3, 0);
        send_point(7, -3, 0);
        send_point(100, 40, 0);
        send_point(100, 40, 1);
        // small arc with negative coordinates
        send_point(-1000, 0, 0);
        send_point(-707, -707, 0);
        send_point(0, -1000, 0);
        send_point(707, -707, 1);

        // random clusters through the idling phases
        sent = 0;
        while (sent < 460) begin
            if (sent >= 400) begin
                tx_idle = 0;
                rx_idle = 0;
                hold_go <= 1;
            end else if (sent >= 200) begin
                tx_idle = 81;
                rx_idle = 37;
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            send_cluster(n);
            sent += n;
        end

        // one cluster past the point count cap
        for (int i = 0; i < LONG_PTS; i++)
            send_point((i % 7) * 3 - 9, (i % 5) * 4 - 8 + i / 64, i == LONG_PTS - 1);
        i_valid <= 0;

        // let the checker see the final beat before polling
        @(negedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
